// File: hw/rtl/rs_enc_pkg.sv
package rs_enc_pkg;

  localparam int unsigned SymWidth     = 10;
  localparam int unsigned MessageDepth = 512;
  localparam int unsigned CodeLength   = 1023;

  localparam logic [SymWidth-1:0] GfTop       = 10'h200;
  localparam logic [SymWidth-1:0] GfReduce    = 10'h009;
  localparam logic [SymWidth-1:0] LengthReset = 10'd512;

  typedef logic [SymWidth-1:0] sym_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POW,
    ST_MAC,
    ST_DONE
  } state_e;

  function automatic sym_t gf_times_alpha(input sym_t v);
    sym_t r;
    if ((v & GfTop) != '0) begin
      r = ((v ^ GfTop) << 1) ^ GfReduce;
    end else begin
      r = v << 1;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/rs_evaluation_encoder_gf1024_unit.sv
// Reed-Solomon evaluation-form encoder over GF(2^10), field polynomial x^10+x^3+1.
// Input stream (s_axis): tuser selects the transaction kind. A load transaction
// writes one message symbol into the message store; an evaluate transaction
// returns codeword symbol i, the message polynomial at alpha^i, on the output
// stream (m_axis) together with the echoed position. Loads beyond the store and
// evaluate points at or above CODE_LENGTH give no result.
// Configuration channel (cfg): writes the message length k, reset value 512;
// lengths above MESSAGE_DEPTH are clamped.
// Timing: a load is written into the store when it is accepted. An evaluate
// transaction first raises alpha to the point index (square-and-multiply, one
// bit a cycle on the shared GF multiplier), then runs k Horner steps on the same
// multiplier with one message-store read per cycle, then moves the result into
// the output register. s_axis_tready_o is low meanwhile, so the next transaction
// is taken only once the evaluate result has gone to the output register.
// Reset: the message store is cleared by a pass over all MESSAGE_DEPTH entries (512
// by default) while s_axis_tready_o stays low; configuration writes are taken.
// Stall: the output register holds a result until taken; loads are accepted
// meanwhile, and a finished evaluation waits until the register is free.
module rs_evaluation_encoder_gf1024_unit #(
  parameter int unsigned MESSAGE_DEPTH = rs_enc_pkg::MessageDepth,
  parameter int unsigned CODE_LENGTH   = rs_enc_pkg::CodeLength
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [8:0] symbol_index, [18:9] symbol_value, [28:19] point_index
  input  logic [31:0] s_axis_tdata_i,
  // [0] kind
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [9:0] codeword_symbol, [19:10] codeword_position
  output logic [23:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_data_i
);

  localparam int unsigned AW = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
  localparam logic [9:0]  DepthW   = 10'(MESSAGE_DEPTH);
  localparam logic [10:0] CodeLenW = 11'(CODE_LENGTH);
  localparam logic [AW-1:0] LastAddr = AW'(MESSAGE_DEPTH - 1);

  rs_enc_pkg::state_e state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [3:0]       bit_q, bit_d;
  logic [9:0]       k_q, k_d;
  logic [9:0]       j_q, j_d;
  logic [9:0]       len_q;
  logic [9:0]       pidx_q, pidx_d;
  rs_enc_pkg::sym_t x_q, x_d;
  rs_enc_pkg::sym_t acc_q, acc_d;
  rs_enc_pkg::sym_t rdata_q;
  logic             out_valid_q, out_valid_d;
  rs_enc_pkg::sym_t out_sym_q, out_sym_d;
  logic [9:0]       out_pos_q, out_pos_d;

  rs_enc_pkg::sym_t mem_q [MESSAGE_DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  rs_enc_pkg::sym_t mem_wdata;
  logic [AW-1:0]    mem_raddr;

  rs_enc_pkg::sym_t mul_a, mul_p, sq_alpha;
  logic             in_acc, kind;
  logic [8:0]       in_sidx;
  rs_enc_pkg::sym_t in_sval;
  logic [9:0]       in_pidx, sidx_w, km1, jm2;
  logic [3:0]       bit_sel;

  assign kind    = s_axis_tuser_i[0];
  assign in_sidx = s_axis_tdata_i[8:0];
  assign in_sval = s_axis_tdata_i[18:9];
  assign in_pidx = s_axis_tdata_i[28:19];
  assign sidx_w  = 10'(in_sidx);
  assign km1     = k_q - 10'd1;
  assign jm2     = j_q - 10'd2;
  assign bit_sel = 4'd9 - bit_q;

  assign s_axis_tready_o = (state_q == rs_enc_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_pos_q, out_sym_q};

  assign mul_a = (state_q == rs_enc_pkg::ST_MAC) ? acc_q : x_q;

  rs_enc_gf_mul u_mul (
    .a_i(mul_a),
    .b_i(x_q),
    .p_o(mul_p)
  );

  assign sq_alpha  = rs_enc_pkg::gf_times_alpha(mul_p);
  assign mem_raddr = (state_q == rs_enc_pkg::ST_MAC) ? jm2[AW-1:0] : km1[AW-1:0];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    bit_d       = bit_q;
    k_d         = k_q;
    j_d         = j_q;
    pidx_d      = pidx_q;
    x_d         = x_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_sym_d   = out_sym_q;
    out_pos_d   = out_pos_q;
    mem_we      = 1'b0;
    mem_waddr   = sidx_w[AW-1:0];
    mem_wdata   = in_sval;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rs_enc_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LastAddr) begin
          state_d = rs_enc_pkg::ST_IDLE;
        end
      end
      rs_enc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!kind) begin
            mem_we = (sidx_w < DepthW);
          end else if ({1'b0, in_pidx} < CodeLenW) begin
            k_d     = (len_q > DepthW) ? DepthW : len_q;
            pidx_d  = in_pidx;
            x_d     = rs_enc_pkg::sym_t'(1);
            acc_d   = '0;
            bit_d   = '0;
            state_d = rs_enc_pkg::ST_POW;
          end
        end
      end
      rs_enc_pkg::ST_POW: begin
        x_d   = pidx_q[bit_sel] ? sq_alpha : mul_p;
        bit_d = bit_q + 4'd1;
        if (bit_q == 4'd9) begin
          j_d     = k_q;
          state_d = (k_q == '0) ? rs_enc_pkg::ST_DONE : rs_enc_pkg::ST_MAC;
        end
      end
      rs_enc_pkg::ST_MAC: begin
        acc_d = mul_p ^ rdata_q;
        j_d   = j_q - 10'd1;
        if (j_q == 10'd1) begin
          state_d = rs_enc_pkg::ST_DONE;
        end
      end
      rs_enc_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_sym_d   = acc_q;
          out_pos_d   = pidx_q;
          state_d     = rs_enc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rs_enc_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rs_enc_pkg::ST_CLEAR;
      clr_q       <= '0;
      bit_q       <= '0;
      j_q         <= '0;
      len_q       <= rs_enc_pkg::LengthReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      bit_q       <= bit_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    pidx_q    <= pidx_d;
    x_q       <= x_d;
    acc_q     <= acc_d;
    out_sym_q <= out_sym_d;
    out_pos_q <= out_pos_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

endmodule

// File: hw/rtl/rs_enc_gf_mul.sv
module rs_enc_gf_mul (
  input  rs_enc_pkg::sym_t a_i,
  input  rs_enc_pkg::sym_t b_i,
  output rs_enc_pkg::sym_t p_o
);

  always_comb begin
    rs_enc_pkg::sym_t acc;
    rs_enc_pkg::sym_t sh;
    acc = '0;
    sh  = a_i;
    for (int i = 0; i < int'(rs_enc_pkg::SymWidth); i++) begin
      if (b_i[i]) begin
        acc = acc ^ sh;
      end
      sh = rs_enc_pkg::gf_times_alpha(sh);
    end
    p_o = acc;
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DrainCycles = rs_enc_pkg::MessageDepth + 20;

  typedef enum logic [0:0] {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } item_kind_e;

  typedef struct packed {
    rs_enc_pkg::sym_t symbol;
    logic [9:0]       position;
  } codeword_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;
  logic [0:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [9:0]  cfg_data_i      = '0;

  rs_enc_pkg::sym_t msg_mem [rs_enc_pkg::MessageDepth];
  logic [9:0]       msg_len;
  codeword_t        codeword_q [$];
  int unsigned      mismatch_count = 0;
  logic             no_stall = 1'b0;

  rs_evaluation_encoder_gf1024_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #100ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic rs_enc_pkg::sym_t times_alpha(input rs_enc_pkg::sym_t v);
    rs_enc_pkg::sym_t r;
    r = {v[8:0], 1'b0};
    if (v[9]) begin
      r = r ^ rs_enc_pkg::GfReduce;
    end
    return r;
  endfunction

  function automatic rs_enc_pkg::sym_t gf_product(input rs_enc_pkg::sym_t a,
                                                  input rs_enc_pkg::sym_t b);
    rs_enc_pkg::sym_t acc;
    rs_enc_pkg::sym_t sh;
    acc = '0;
    sh  = a;
    for (int i = 0; i < 10; i++) begin
      if (b[i]) begin
        acc = acc ^ sh;
      end
      sh = times_alpha(sh);
    end
    return acc;
  endfunction

  function automatic rs_enc_pkg::sym_t codeword_at(input logic [9:0] point);
    rs_enc_pkg::sym_t x;
    rs_enc_pkg::sym_t acc;
    int unsigned      k;
    x = 10'd1;
    for (int n = 0; n < int'(point); n++) begin
      x = times_alpha(x);
    end
    k   = (msg_len > rs_enc_pkg::MessageDepth) ? rs_enc_pkg::MessageDepth : 32'(msg_len);
    acc = '0;
    for (int j = int'(k); j > 0; j--) begin
      acc = gf_product(acc, x) ^ msg_mem[j-1];
    end
    return acc;
  endfunction

  always @(posedge clk_i) begin : check_codeword
    codeword_t got;
    codeword_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[9:0], m_axis_tdata_o[19:10]};
      if (codeword_q.size() == 0) begin
        $display("%0t: unexpected codeword, expected none, actual symbol %h position %0d",
                 $time, got.symbol, got.position);
        mismatch_count++;
      end else begin
        want = codeword_q.pop_front();
        if (got.symbol !== want.symbol) begin
          $display("%0t: codeword_symbol mismatch, expected %h, actual %h",
                   $time, want.symbol, got.symbol);
          mismatch_count++;
        end
        if (got.position !== want.position) begin
          $display("%0t: codeword_position mismatch, expected %0d, actual %0d",
                   $time, want.position, got.position);
          mismatch_count++;
        end
      end
    end
    m_axis_tready_i <= no_stall || ($urandom_range(99) >= 11);
  end

  task automatic send_item(input item_kind_e kind, input logic [8:0] sidx,
                           input rs_enc_pkg::sym_t sval, input logic [9:0] pidx);
    if (!no_stall && $urandom_range(99) < 11) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, pidx, sval, sidx};
    s_axis_tuser_i  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (kind == KIND_LOAD) begin
      if (sidx < rs_enc_pkg::MessageDepth) begin
        msg_mem[sidx] = sval;
      end
    end else if (pidx < rs_enc_pkg::CodeLength) begin
      codeword_q.push_back({codeword_at(pidx), pidx});
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (codeword_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_msg_len(input logic [9:0] len);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    msg_len = len;
  endtask

  task automatic random_item(input int unsigned span);
    item_kind_e       kind;
    logic [8:0]       sidx;
    rs_enc_pkg::sym_t sval;
    logic [9:0]       pidx;
    kind = item_kind_e'($urandom_range(1));
    sidx = 9'($urandom_range(0, 511));
    sval = 10'($urandom_range(0, 1023));
    pidx = 10'($urandom_range(0, 1023));
    if (kind == KIND_LOAD && span > 0 && $urandom_range(1)) begin
      sidx = 9'($urandom_range(0, span - 1));
    end
    if (kind == KIND_EVAL) begin
      pidx = ($urandom_range(99) < 4) ? 10'd1023 :
             10'($urandom_range(0, rs_enc_pkg::CodeLength - 1));
    end
    send_item(kind, sidx, sval, pidx);
  endtask

  task automatic test_cleared_store();
    send_item(KIND_EVAL, 9'd0, 10'd0, 10'd0);
    send_item(KIND_EVAL, 9'd0, 10'd0, 10'd1022);
    send_item(KIND_EVAL, 9'd0, 10'd0, 10'd1023);
    send_item(KIND_LOAD, 9'd0, 10'h3FF, 10'd0);
    send_item(KIND_LOAD, 9'd511, 10'h3FF, 10'd1023);
    send_item(KIND_LOAD, 9'h155, 10'h155, 10'h2AA);
    send_item(KIND_LOAD, 9'h0AA, 10'h2AA, 10'h155);
    send_item(KIND_EVAL, 9'h1FF, 10'h3FF, 10'd0);
    send_item(KIND_EVAL, 9'd0, 10'd0, 10'd1);
    send_item(KIND_EVAL, 9'd0, 10'd0, 10'd1022);
    send_item(KIND_EVAL, 9'h155, 10'h2AA, 10'd512);
  endtask

  task automatic test_length_limits();
    write_msg_len(10'd1023);
    send_item(KIND_EVAL, 9'd0, 10'd0, 10'd5);
    send_item(KIND_EVAL, 9'd0, 10'd0, 10'd1022);
    write_msg_len(10'd0);
    send_item(KIND_EVAL, 9'd3, 10'd9, 10'd7);
    write_msg_len(10'd1);
    send_item(KIND_EVAL, 9'd0, 10'd0, 10'd1022);
    send_item(KIND_LOAD, 9'd0, 10'h001, 10'd1023);
    send_item(KIND_EVAL, 9'd0, 10'd0, 10'd300);
    write_msg_len(10'd513);
    send_item(KIND_EVAL, 9'd0, 10'd0, 10'd3);
  endtask

  task automatic test_random_short();
    int unsigned len;
    for (int phase = 0; phase < 6; phase++) begin
      len = $urandom_range(1, 48);
      write_msg_len(len[9:0]);
      repeat (120) random_item(len);
    end
  endtask

  task automatic test_random_full();
    write_msg_len(10'd512);
    repeat (80) random_item(rs_enc_pkg::MessageDepth);
  endtask

  task automatic test_no_stall();
    int unsigned len;
    len = $urandom_range(1, 32);
    write_msg_len(len[9:0]);
    no_stall = 1'b1;
    repeat (200) random_item(len);
    drain();
    no_stall = 1'b0;
  endtask

  initial begin
    for (int j = 0; j < rs_enc_pkg::MessageDepth; j++) begin
      msg_mem[j] = '0;
    end
    msg_len = rs_enc_pkg::LengthReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_cleared_store();
    test_length_limits();
    test_random_short();
    test_random_full();
    test_no_stall();
    drain();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rs_enc_pkg.sv
hw/rtl/rs_enc_gf_mul.sv
hw/rtl/rs_evaluation_encoder_gf1024_unit.sv
test/tb.sv
